// ===== hw/rtl/vta_pkg.sv =====
// vta_pkg: shared widths, types, register indexes and helpers for the
// vertex transform and bounding box block. No dependencies.
`default_nettype none

package vta_pkg;

  // base formats
  localparam int CoordWidth = 21;
  localparam int QuatWidth  = 16;
  localparam int CoordFrac  = 10;
  localparam int PackField  = 21;
  localparam int PackWidth  = 3 * PackField;
  localparam int CfgIdxW    = 3;
  localparam int QuatFrac   = QuatWidth - 2;

  // datapath widths
  localparam int DiffW  = CoordWidth + 1;            // vector minus centroid
  localparam int Prod1W = QuatWidth + DiffW;         // q * d
  localparam int TSumW  = Prod1W + 2;                // 2 * (cross difference)
  localparam int TW     = TSumW - QuatFrac;          // t after rounding
  localparam int Prod2W = QuatWidth + TW;            // q * t
  localparam int CSumW  = Prod2W + 1;
  localparam int CW     = CSumW - QuatFrac;          // rounded cross or w*t
  localparam int RSumW  = CW + 2;                    // d + w*t + c
  localparam int SProdW = 2 * CoordWidth + 1;        // r * scale plus half
  localparam int SW     = SProdW - CoordFrac;
  localparam int SatIn  = 64;

  localparam int NextAx [3] = '{1, 2, 0};
  localparam int PrevAx [3] = '{2, 0, 1};

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [QuatWidth-1:0]  quat_t;
  typedef logic signed [DiffW-1:0]      diff_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegQuatW   = 3'd0,
    RegQuatX   = 3'd1,
    RegQuatY   = 3'd2,
    RegQuatZ   = 3'd3,
    RegScale   = 3'd4,
    RegLocalC  = 3'd5,
    RegInstC   = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BkIdle, BkRotT, BkRotC, BkScale, BkFin, BkOut
  } back_state_e;

  // unpacked configuration handed to the datapath
  typedef struct packed {
    quat_t  qw;
    quat_t  qx;
    quat_t  qy;
    quat_t  qz;
    coord_t sx;
    coord_t sy;
    coord_t sz;
    coord_t lx;
    coord_t ly;
    coord_t lz;
    coord_t ix;
    coord_t iy;
    coord_t iz;
  } cfg_t;

  // queued work item
  typedef struct packed {
    logic  normal;
    logic  last;
    diff_t dx;
    diff_t dy;
    diff_t dz;
  } item_t;

  // clamp a sign-extended value into the coordinate range
  function automatic coord_t sat_coord(input logic signed [SatIn-1:0] x);
    logic signed [SatIn-1:0] hi;
    logic signed [SatIn-1:0] lo;
    hi = SatIn'((64'sd1 <<< (CoordWidth - 1)) - 64'sd1);
    lo = -hi - SatIn'(64'sd1);
    if (x > hi) return coord_t'(hi);
    if (x < lo) return coord_t'(lo);
    return coord_t'(x);
  endfunction

  // one packed field: sign extend then clamp
  function automatic coord_t unpack_field(input logic [PackField-1:0] f);
    logic signed [PackField-1:0] s;
    s = signed'(f);
    return sat_coord(SatIn'(s));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vta_cfg.sv =====
// vta_cfg: configuration register file with unpacking of the packed fields.
// Depends on vta_pkg.
`default_nettype none

module vta_cfg import vta_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [PackWidth-1:0]  cfg_data_i,
  output cfg_t                       cfg_o
);

  logic [QuatWidth-1:0] qw_q, qx_q, qy_q, qz_q;
  logic [PackWidth-1:0] scale_q, local_q, inst_q;
  logic [PackField-1:0] one_f;

  assign one_f = PackField'(1 << CoordFrac);

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q    <= QuatWidth'(1 << QuatFrac);
      qx_q    <= '0;
      qy_q    <= '0;
      qz_q    <= '0;
      scale_q <= {one_f, one_f, one_f};
      local_q <= '0;
      inst_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        RegQuatW:  qw_q    <= cfg_data_i[QuatWidth-1:0];
        RegQuatX:  qx_q    <= cfg_data_i[QuatWidth-1:0];
        RegQuatY:  qy_q    <= cfg_data_i[QuatWidth-1:0];
        RegQuatZ:  qz_q    <= cfg_data_i[QuatWidth-1:0];
        RegScale:  scale_q <= cfg_data_i;
        RegLocalC: local_q <= cfg_data_i;
        RegInstC:  inst_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // field views
  always_comb begin
    cfg_o.qw = signed'(qw_q);
    cfg_o.qx = signed'(qx_q);
    cfg_o.qy = signed'(qy_q);
    cfg_o.qz = signed'(qz_q);
    cfg_o.sx = unpack_field(scale_q[PackField-1:0]);
    cfg_o.sy = unpack_field(scale_q[2*PackField-1:PackField]);
    cfg_o.sz = unpack_field(scale_q[3*PackField-1:2*PackField]);
    cfg_o.lx = unpack_field(local_q[PackField-1:0]);
    cfg_o.ly = unpack_field(local_q[2*PackField-1:PackField]);
    cfg_o.lz = unpack_field(local_q[3*PackField-1:2*PackField]);
    cfg_o.ix = unpack_field(inst_q[PackField-1:0]);
    cfg_o.iy = unpack_field(inst_q[2*PackField-1:PackField]);
    cfg_o.iz = unpack_field(inst_q[3*PackField-1:2*PackField]);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vta_front.sv =====
// vta_front: takes requests, removes the local centroid from vertices and
// queues the work in a two-entry queue. Depends on vta_pkg.
`default_nettype none

module vta_front import vta_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  cfg_t         cfg_i,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire logic    in_normal_i,
  input  wire logic    in_last_i,
  input  coord_t       in_x_i,
  input  coord_t       in_y_i,
  input  coord_t       in_z_i,
  output logic         q_valid_o,
  output item_t        q_item_o,
  input  wire logic    q_pop_i
);

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  item_t       push_item;
  logic        push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  // classify and subtract centroid for vertices
  always_comb begin
    push_item.normal = in_normal_i;
    push_item.last   = in_last_i;
    if (in_normal_i) begin
      push_item.dx = DiffW'(in_x_i);
      push_item.dy = DiffW'(in_y_i);
      push_item.dz = DiffW'(in_z_i);
    end else begin
      push_item.dx = DiffW'(in_x_i) - DiffW'(cfg_i.lx);
      push_item.dy = DiffW'(in_y_i) - DiffW'(cfg_i.ly);
      push_item.dz = DiffW'(in_z_i) - DiffW'(cfg_i.lz);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vta_back.sv =====
// vta_back: sequenced rotate, scale, offset and bounding box update with a
// held result register. Depends on vta_pkg.
`default_nettype none

module vta_back import vta_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  cfg_t         cfg_i,
  input  wire logic    q_valid_i,
  input  item_t        q_item_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output coord_t       res_o [3],
  output coord_t       lo_o [3],
  output coord_t       hi_o [3],
  output logic         final_o
);

  back_state_e state_q, state_d;

  logic                     norm_q, last_q;
  diff_t                    d_q [3];
  logic signed [TW-1:0]     t_q [3];
  coord_t                   r_q [3];
  coord_t                   s_q [3];
  coord_t                   lo_q [3], hi_q [3];
  logic                     empty_q;
  coord_t                   res_q [3];
  logic                     final_q;

  quat_t                    qv [3];
  coord_t                   sc [3];
  coord_t                   ic [3];
  diff_t                    di [3];
  logic signed [TW-1:0]     t_d [3];
  coord_t                   r_d [3];
  coord_t                   s_d [3];
  coord_t                   f_d [3];

  assign qv = '{cfg_i.qx, cfg_i.qy, cfg_i.qz};
  assign sc = '{cfg_i.sx, cfg_i.sy, cfg_i.sz};
  assign ic = '{cfg_i.ix, cfg_i.iy, cfg_i.iz};
  assign di = '{q_item_i.dx, q_item_i.dy, q_item_i.dz};

  // sequencer
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = BkRotT;
        end
      end
      BkRotT:  state_d = BkRotC;
      BkRotC:  state_d = BkScale;
      BkScale: state_d = BkFin;
      BkFin:   state_d = BkOut;
      BkOut: begin
        if (out_ready_i) begin
          if (q_valid_i) begin
            q_pop_o = 1'b1;
            state_d = BkRotT;
          end else begin
            state_d = BkIdle;
          end
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BkIdle;
    else         state_q <= state_d;
  end

  // t = 2 * (qv x d), rounded
  always_comb begin
    logic signed [TSumW-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      acc = (TSumW'(qv[NextAx[i]]) * d_q[PrevAx[i]] -
             TSumW'(qv[PrevAx[i]]) * d_q[NextAx[i]]) <<< 1;
      acc = acc + TSumW'(1 <<< (QuatFrac - 1));
      t_d[i] = TW'(acc >>> QuatFrac);
    end
  end

  // d + w*t + qv x t, rounded and clamped
  always_comb begin
    logic signed [CSumW-1:0] cx;
    logic signed [CSumW-1:0] wt;
    logic signed [RSumW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      cx = CSumW'(qv[NextAx[i]]) * t_q[PrevAx[i]] -
           CSumW'(qv[PrevAx[i]]) * t_q[NextAx[i]] + CSumW'(1 <<< (QuatFrac - 1));
      wt = CSumW'(cfg_i.qw) * t_q[i] + CSumW'(1 <<< (QuatFrac - 1));
      sum = RSumW'(d_q[i]) + RSumW'(CW'(wt >>> QuatFrac)) + RSumW'(CW'(cx >>> QuatFrac));
      r_d[i] = sat_coord(SatIn'(sum));
    end
  end

  // per-axis scale, rounded and clamped
  always_comb begin
    logic signed [SProdW-1:0] sp;
    for (int i = 0; i < 3; i++) begin
      sp = SProdW'(r_q[i]) * sc[i] + SProdW'(1 <<< (CoordFrac - 1));
      s_d[i] = sat_coord(SatIn'(SW'(sp >>> CoordFrac)));
    end
  end

  // instance offset for vertices; normals keep the rotated value
  always_comb begin
    logic signed [CoordWidth:0] ad;
    for (int i = 0; i < 3; i++) begin
      ad = (CoordWidth+1)'(s_q[i]) + (CoordWidth+1)'(ic[i]);
      f_d[i] = norm_q ? r_q[i] : sat_coord(SatIn'(ad));
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      norm_q <= q_item_i.normal;
      last_q <= q_item_i.last;
      d_q    <= di;
    end
    if (state_q == BkRotT)  t_q <= t_d;
    if (state_q == BkRotC)  r_q <= r_d;
    if (state_q == BkScale) s_q <= s_d;
    if (state_q == BkFin)   res_q <= f_d;
  end

  // bounding box and closing flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= '{default: '0};
      hi_q    <= '{default: '0};
      empty_q <= 1'b1;
      final_q <= 1'b0;
    end else if (state_q == BkFin) begin
      final_q <= !norm_q && last_q;
      if (!norm_q) begin
        for (int i = 0; i < 3; i++) begin
          if (empty_q || f_d[i] < lo_q[i]) lo_q[i] <= f_d[i];
          if (empty_q || f_d[i] > hi_q[i]) hi_q[i] <= f_d[i];
        end
        empty_q <= last_q;
      end
    end
  end

  assign out_valid_o = (state_q == BkOut);
  assign res_o       = res_q;
  assign lo_o        = lo_q;
  assign hi_o        = hi_q;
  assign final_o     = final_q;

  // checks
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i) else $error("pop from empty queue");
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && final_o) |-> empty_q) else $error("closed box not emptied");
  a_box_x_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q[0] <= hi_q[0]) else $error("box x inverted");
  a_box_y_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q[1] <= hi_q[1]) else $error("box y inverted");
  a_fin_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkFin) |=> out_valid_o) else $error("result not presented");

endmodule

`default_nettype wire

// ===== hw/rtl/vertex_transform_aabb.sv =====
// Vertex transform with running bounding box: one result per request.
// Each item passes through the rotate, scale, finish and output states of the
// shared rotate/scale sequencer; the next item is taken once the result is accepted.
// Input requests queue two deep, so input is taken while a result waits.
// Reset (async, active low) loads identity rotation, unit scale, zero
// centroids and an empty box.
`default_nettype none

module vertex_transform_aabb import vta_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [PackWidth-1:0]  cfg_data_i,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [63:0]           s_axis_tdata,  // vec_x, vec_y, vec_z, zero pad
  input  wire logic                  s_axis_tuser,  // operation
  input  wire logic                  s_axis_tlast,  // last_vertex
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_x, out_y, out_z, box_min_x/y/z, box_max_x/y/z, zero pad
  output logic [191:0]               m_axis_tdata,
  output logic                       m_axis_tlast   // box_final
);

  cfg_t   cfg;
  logic   q_valid, q_pop;
  item_t  q_item;
  coord_t res [3], lo [3], hi [3];
  logic   fin;

  assign cfg_ready_o = 1'b1;

  vta_cfg u_cfg (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .cfg_o (cfg)
  );

  vta_front u_front (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_normal_i (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .in_x_i      (signed'(s_axis_tdata[CoordWidth-1:0])),
    .in_y_i      (signed'(s_axis_tdata[2*CoordWidth-1:CoordWidth])),
    .in_z_i      (signed'(s_axis_tdata[3*CoordWidth-1:2*CoordWidth])),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  vta_back u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res),
    .lo_o        (lo),
    .hi_o        (hi),
    .final_o     (fin)
  );

  // result packing
  assign m_axis_tdata = 192'({hi[2], hi[1], hi[0], lo[2], lo[1], lo[0],
                              res[2], res[1], res[0]});
  assign m_axis_tlast = fin;

endmodule

`default_nettype wire

// ===== test/vertex_transform_aabb_test.sv =====
// vertex_transform_aabb_test: self-checking bench for the vertex transform and
// bounding box block. Depends on vta_pkg and vertex_transform_aabb.
`default_nettype none

module vertex_transform_aabb_test;
  import vta_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandItems  = 650;
  localparam int DrainWait  = 40;

  // one result item
  typedef struct packed {
    logic         fin;
    logic [191:0] data;
  } xform_res_t;

  // one stimulus row; chk set when exp is typed in
  typedef struct {
    logic         op;
    logic [20:0]  vx;
    logic [20:0]  vy;
    logic [20:0]  vz;
    logic         lastv;
    logic         chk;
    logic [191:0] exp;
  } vec_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [PackWidth-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic m_axis_tlast;

  vertex_transform_aabb dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of registers and box
  longint q_w, q_x, q_y, q_z;
  logic [62:0] scale_r, lcen_r, icen_r;
  longint lo_c [3];
  longint hi_c [3];
  bit box_open_empty;

  xform_res_t pending_res [$];
  int n_err = 0;
  int n_cyc = 0;

  function automatic longint sx(logic [63:0] v, int w);
    logic [63:0] m;
    m = (w == 64) ? '1 : ((64'd1 << w) - 1);
    v = v & m;
    if (v[w-1]) return longint'(v | ~m);
    return longint'(v);
  endfunction

  function automatic longint rnd_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp21(longint x);
    if (x > 1048575) return 1048575;
    if (x < -1048576) return -1048576;
    return x;
  endfunction

  function automatic void set_reg(cfg_idx_e idx, logic [62:0] v);
    case (idx)
      RegQuatW:  q_w = sx(v, QuatWidth);
      RegQuatX:  q_x = sx(v, QuatWidth);
      RegQuatY:  q_y = sx(v, QuatWidth);
      RegQuatZ:  q_z = sx(v, QuatWidth);
      RegScale:  scale_r = v;
      RegLocalC: lcen_r = v;
      RegInstC:  icen_r = v;
      default: ;
    endcase
  endfunction

  // quaternion rotation: t = 2 qv x v, v' = v + w t + qv x t
  function automatic void quat_rotate(input longint v [3], output longint o [3]);
    longint q [3];
    longint t [3];
    longint c;
    q[0] = q_x; q[1] = q_y; q[2] = q_z;
    for (int i = 0; i < 3; i++)
      t[i] = rnd_shift(2 * (q[(i+1)%3] * v[(i+2)%3] - q[(i+2)%3] * v[(i+1)%3]),
                       QuatFrac);
    for (int i = 0; i < 3; i++) begin
      c = rnd_shift(q[(i+1)%3] * t[(i+2)%3] - q[(i+2)%3] * t[(i+1)%3], QuatFrac);
      o[i] = clamp21(v[i] + rnd_shift(q_w * t[i], QuatFrac) + c);
    end
  endfunction

  function automatic xform_res_t transform_vertex(logic op, logic [20:0] vx,
                                                  logic [20:0] vy, logic [20:0] vz,
                                                  logic lastv);
    longint v [3];
    longint r [3];
    longint res [3];
    longint s;
    xform_res_t o;
    v[0] = sx(vx, 21); v[1] = sx(vy, 21); v[2] = sx(vz, 21);
    o.fin = 1'b0;
    if (op) begin
      quat_rotate(v, res);
    end else begin
      for (int i = 0; i < 3; i++) v[i] = v[i] - sx(lcen_r >> (21 * i), 21);
      quat_rotate(v, r);
      for (int i = 0; i < 3; i++) begin
        s = clamp21(rnd_shift(r[i] * sx(scale_r >> (21 * i), 21), CoordFrac));
        res[i] = clamp21(s + sx(icen_r >> (21 * i), 21));
        if (box_open_empty) begin
          lo_c[i] = res[i]; hi_c[i] = res[i];
        end else begin
          if (res[i] < lo_c[i]) lo_c[i] = res[i];
          if (res[i] > hi_c[i]) hi_c[i] = res[i];
        end
      end
      box_open_empty = 1'b0;
      if (lastv) begin
        o.fin = 1'b1;
        box_open_empty = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      o.data[21*i +: 21]     = res[i][20:0];
      o.data[63 + 21*i +: 21] = lo_c[i][20:0];
      o.data[126 + 21*i +: 21] = hi_c[i][20:0];
    end
    o.data[191:189] = '0;
    return o;
  endfunction

  // cycle counter and timeout
  always @(posedge clk_i) begin
    n_cyc <= n_cyc + 1;
    if (n_cyc > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls and compare
  int out_wait = 0;
  always @(posedge clk_i) begin
    xform_res_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_res.size() == 0) begin
          n_err = n_err + 1;
          if (n_err <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          exp_r = pending_res.pop_front();
          if (exp_r.data !== m_axis_tdata || exp_r.fin !== m_axis_tlast) begin
            n_err = n_err + 1;
            if (n_err <= 10)
              $display("mismatch: exp %h fin %b, got %h fin %b",
                       exp_r.data, exp_r.fin, m_axis_tdata, m_axis_tlast);
          end
        end
        out_wait = (n_cyc % 400 < 100) ? 0 : $urandom_range(0, 9);
      end
      if (out_wait > 0) begin
        out_wait = out_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [62:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    set_reg(idx, v);
  endtask

  // stop the input side and let all results drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // send one request; check typed-in expectation for directed rows
  task automatic send_vec(vec_row_t row);
    xform_res_t e;
    int gap;
    gap = (n_cyc % 500 < 120) ? 0 : $urandom_range(0, 9);
    // valid stays high only when the next request follows at once
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= row.op;
    s_axis_tlast <= row.lastv;
    s_axis_tdata <= {1'b0, row.vz, row.vy, row.vx};
    do @(posedge clk_i); while (!s_axis_tready);
    e = transform_vertex(row.op, row.vx, row.vy, row.vz, row.lastv);
    if (row.chk && e.data !== row.exp) begin
      n_err = n_err + 1;
      if (n_err <= 10) $display("directed row: exp %h pred %h", row.exp, e.data);
    end
    pending_res.push_back(e);
  endtask

  function automatic logic [62:0] pack3(logic [20:0] a, logic [20:0] b, logic [20:0] c);
    return {c, b, a};
  endfunction

  function automatic logic [20:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 21'h0FFFFF;
      1: return 21'h100000;
      2: return 21'($urandom_range(0, 8191)) - 21'd4096;
      default: return 21'($urandom);
    endcase
  endfunction

  vec_row_t dir_rows [$];
  vec_row_t row;
  logic [20:0] vmax, vmin;

  initial begin
    q_w = 16384; q_x = 0; q_y = 0; q_z = 0;
    // 1.0 on each axis
    scale_r = pack3(21'd1024, 21'd1024, 21'd1024);
    lcen_r = '0; icen_r = '0;
    for (int i = 0; i < 3; i++) begin lo_c[i] = 0; hi_c[i] = 0; end
    box_open_empty = 1'b1;
    vmax = 21'h0FFFFF; vmin = 21'h100000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: identity transform after reset, extremes, normals, closing
    dir_rows.push_back('{0, 21'd5, 21'd7, 21'd9, 0, 1,
                         {3'b0, 63'(pack3(21'd5, 21'd7, 21'd9)),
                          63'(pack3(21'd5, 21'd7, 21'd9)), 63'(pack3(21'd5, 21'd7, 21'd9))}});
    dir_rows.push_back('{0, vmax, vmin, vmax, 0, 1,
                         {3'b0, 63'(pack3(vmax, 21'd7, vmax)),
                          63'(pack3(21'd5, vmin, 21'd9)), 63'(pack3(vmax, vmin, vmax))}});
    dir_rows.push_back('{1, vmin, vmax, 21'd0, 1, 0, '0});
    dir_rows.push_back('{0, vmin, vmin, vmin, 1, 0, '0});
    dir_rows.push_back('{0, 21'd0, 21'd0, 21'd0, 1, 0, '0});
    dir_rows.push_back('{1, 21'd0, 21'd0, 21'd0, 0, 0, '0});
    foreach (dir_rows[i]) send_vec(dir_rows[i]);
    wait_idle();

    // rotation, scale and centroid extremes
    write_reg(RegQuatW, 63'h8000);
    write_reg(RegQuatX, 63'h7FFF);
    write_reg(RegQuatY, 63'h8000);
    write_reg(RegQuatZ, 63'h2D41);
    write_reg(RegScale, pack3(vmax, vmin, 21'd2048));
    write_reg(RegLocalC, pack3(vmin, vmax, 21'd100));
    write_reg(RegInstC, pack3(vmax, 21'd0, vmin));
    for (int i = 0; i < 8; i++) begin
      row = '{i[0], (i[1] ? vmax : vmin), (i[2] ? vmax : vmin), 21'd3, i == 7, 0, '0};
      send_vec(row);
    end
    wait_idle();

    // random phases, each with a new register setting
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        write_reg(RegQuatW, 63'd16384);
        write_reg(RegQuatX, 63'd0);
        write_reg(RegQuatY, 63'd0);
        write_reg(RegQuatZ, 63'd0);
        write_reg(RegScale, pack3(21'd1024, 21'd1024, 21'd1024));
      end else begin
        write_reg(RegQuatW, 63'($urandom_range(0, 65535)));
        write_reg(RegQuatX, 63'($urandom_range(0, 65535)));
        write_reg(RegQuatY, 63'($urandom_range(0, 65535)));
        write_reg(RegQuatZ, 63'($urandom_range(0, 65535)));
        write_reg(RegScale, ph == 5 ? 63'h7FFF_FFFF_FFFF_FFFF
                                    : pack3(rnd_coord(), rnd_coord(), rnd_coord()));
        write_reg(RegLocalC, 63'({$urandom, $urandom}));
        write_reg(RegInstC, 63'({$urandom, $urandom}));
      end
      // meshes of a few vertices with normals mixed in
      for (int k = 0; k < RandItems / 6; k++) begin
        row = '{($urandom_range(0, 3) == 0), rnd_coord(), rnd_coord(), rnd_coord(),
                ($urandom_range(0, 7) == 0), 0, '0};
        send_vec(row);
      end
      wait_idle();
    end

    repeat (DrainWait) @(posedge clk_i);
    if (n_err == 0 && pending_res.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
